### rtl/core/bcl_pkg.sv
// types and constants shared by the bounded cursor list
`default_nettype none

package bcl_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 4;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_BEFORE = 4'd0,
        ACT_INS_AFTER  = 4'd1,
        ACT_REP_BEFORE = 4'd2,
        ACT_REP_AT     = 4'd3,
        ACT_REP_AFTER  = 4'd4,
        ACT_REMOVE     = 4'd5,
        ACT_BEGIN      = 4'd6,
        ACT_END        = 4'd7,
        ACT_NEXT       = 4'd8,
        ACT_PRIOR      = 4'd9,
        ACT_CLEAR      = 4'd10
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic success;
        logic is_empty;
        logic is_full;
    } t_res_flags;

endpackage

`default_nettype wire

### rtl/core/bounded_cursor_list.sv
// top level of the bounded cursor list
// the sequencer holds one item at a time; results leave through an output register
// insert: time grows with the entries behind the insertion point, set by the entry shift loop
// remove: time grows with the entries from the cursor to the tail, same shift loop
// other actions run no shift loop; one memory read and one write per cycle bound every loop
// reset clears count, cursor and result valid, loads capacity 64; entry memory is not cleared
`default_nettype none

module bounded_cursor_list #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // action [3:0], data_value [35:4], zero fill
    input  wire logic [39:0]                s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // success, data_out, entry_total, is_empty, is_full, zero fill
    output logic [((35 + $clog2(MAX_ENTRIES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [bcl_pkg::CAP_W-1:0]  i_cfg_wr_data
);
    import bcl_pkg::*;

    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int RES_W = 3 + DATA_W + CW;
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [DATA_W-1:0] w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    logic [DATA_W-1:0] w_mem_rdata;

    logic              w_res_valid;
    logic              w_res_ready;
    t_res_flags        w_res_flags;
    logic [DATA_W-1:0] w_res_data;
    logic [CW-1:0]     w_res_count;
    logic [OUT_W-1:0]  w_res_beat;

    bcl_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    bcl_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_action      (s_axis_tdata[ACT_W-1:0]),
        .i_value       (s_axis_tdata[ACT_W+DATA_W-1:ACT_W]),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res_flags   (w_res_flags),
        .o_res_data    (w_res_data),
        .o_res_count   (w_res_count),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_re      (w_mem_re),
        .o_mem_raddr   (w_mem_raddr),
        .i_mem_rdata   (w_mem_rdata)
    );

    assign w_res_beat = OUT_W'({w_res_flags.is_full, w_res_flags.is_empty, w_res_count,
                                w_res_data, w_res_flags.success});

    bcl_obuf #(
        .W (OUT_W)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res_beat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/core/bcl_mem.sv
// entry memory: one write port, one read port with registered read data
`default_nettype none

module bcl_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [bcl_pkg::DATA_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [bcl_pkg::DATA_W-1:0] o_rdata
);
    import bcl_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/bcl_ctrl.sv
// action sequencer: count, cursor, capacity register and shift control
`default_nettype none

module bcl_ctrl #(
    parameter int MAX_ENTRIES = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [bcl_pkg::CAP_W-1:0]  i_cfg_wr_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [bcl_pkg::ACT_W-1:0]  i_action,
    input  wire logic [bcl_pkg::DATA_W-1:0] i_value,
    output logic                            o_res_valid,
    input  wire logic                       i_res_ready,
    output bcl_pkg::t_res_flags             o_res_flags,
    output logic      [bcl_pkg::DATA_W-1:0] o_res_data,
    output logic      [CW-1:0]              o_res_count,
    output logic                            o_mem_we,
    output logic      [AW-1:0]              o_mem_waddr,
    output logic      [bcl_pkg::DATA_W-1:0] o_mem_wdata,
    output logic                            o_mem_re,
    output logic      [AW-1:0]              o_mem_raddr,
    input  wire logic [bcl_pkg::DATA_W-1:0] i_mem_rdata
);
    import bcl_pkg::*;

    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_rd_v, n_rd_v;
    logic              r_rd_after, n_rd_after;
    logic              r_ok, n_ok;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic [DATA_W-1:0] r_value, n_value;
    logic [DATA_W-1:0] r_dout, n_dout;

    logic [LW-1:0]     w_cap_ext;
    logic [LW-1:0]     w_lim;
    logic              w_full;
    logic              w_ne;
    logic [CW-1:0]     w_cur_cw;
    logic [CW-1:0]     w_cur_p1;
    logic [CW-1:0]     w_ins_pos;
    logic              w_rd_issue;

    assign w_cap_ext = LW'(r_cap);
    assign w_lim     = (r_cap == '0) ? LW'(1) :
                       ((w_cap_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : w_cap_ext);
    assign w_full    = LW'(r_count) >= w_lim;
    assign w_ne      = r_count != '0;
    assign w_cur_cw  = CW'(r_cur);
    assign w_cur_p1  = w_cur_cw + CW'(1);
    assign w_ins_pos = (i_action == ACT_INS_AFTER) ? w_cur_p1 : w_cur_cw;
    assign w_rd_issue = r_idx <= r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_cur   <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cur   <= n_cur;
            r_rd_v  <= n_rd_v;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_idx      <= n_idx;
        r_rd_after <= n_rd_after;
        r_ok       <= n_ok;
        r_wr_addr  <= n_wr_addr;
        r_value    <= n_value;
        r_dout     <= n_dout;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_rd_v      = r_rd_v;
        n_rd_after  = r_rd_after;
        n_ok        = r_ok;
        n_wr_addr   = r_wr_addr;
        n_value     = r_value;
        n_dout      = r_dout;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_wr_addr;
        o_mem_wdata = r_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cur;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_ok       = 1'b0;
                    n_dout     = '0;
                    n_value    = i_value;
                    n_rd_v     = 1'b0;
                    n_rd_after = 1'b0;
                    n_state    = ST_DONE;
                    unique case (i_action)
                        ACT_INS_BEFORE, ACT_INS_AFTER: begin
                            if (!w_ne) begin
                                n_ok      = 1'b1;
                                n_dout    = i_value;
                                n_count   = CW'(1);
                                n_cur     = '0;
                                n_wr_addr = '0;
                                n_state   = ST_WRITE;
                            end else if (w_full) begin
                                n_state = ST_READ;
                            end else begin
                                n_ok      = 1'b1;
                                n_dout    = i_value;
                                n_pos     = w_ins_pos;
                                n_cur     = AW'(w_ins_pos);
                                n_wr_addr = AW'(w_ins_pos);
                                n_idx     = r_count;
                                n_count   = r_count + CW'(1);
                                n_state   = (w_ins_pos == r_count) ? ST_WRITE : ST_SHIFT_UP;
                            end
                        end
                        ACT_REP_BEFORE: begin
                            if (w_ne && r_cur != '0) begin
                                n_ok       = 1'b1;
                                n_wr_addr  = r_cur - AW'(1);
                                n_rd_after = 1'b1;
                                n_state    = ST_WRITE;
                            end else if (w_ne) begin
                                n_state = ST_READ;
                            end
                        end
                        ACT_REP_AT: begin
                            if (w_ne) begin
                                n_ok      = 1'b1;
                                n_dout    = i_value;
                                n_wr_addr = r_cur;
                                n_state   = ST_WRITE;
                            end
                        end
                        ACT_REP_AFTER: begin
                            if (w_ne && w_cur_p1 < r_count) begin
                                n_ok       = 1'b1;
                                n_wr_addr  = AW'(w_cur_p1);
                                n_rd_after = 1'b1;
                                n_state    = ST_WRITE;
                            end else if (w_ne) begin
                                n_state = ST_READ;
                            end
                        end
                        ACT_REMOVE: begin
                            if (w_ne) begin
                                n_ok    = 1'b1;
                                n_pos   = w_cur_cw;
                                n_idx   = w_cur_cw;
                                n_count = r_count - CW'(1);
                                if (w_cur_p1 >= r_count && r_cur != '0) begin
                                    n_cur = r_cur - AW'(1);
                                end
                                n_state = ST_SHIFT_DN;
                            end
                        end
                        ACT_BEGIN: begin
                            if (w_ne) begin
                                n_ok    = 1'b1;
                                n_cur   = '0;
                                n_state = ST_READ;
                            end
                        end
                        ACT_END: begin
                            if (w_ne) begin
                                n_ok    = 1'b1;
                                n_cur   = AW'(r_count - CW'(1));
                                n_state = ST_READ;
                            end
                        end
                        ACT_NEXT: begin
                            if (w_ne) begin
                                if (w_cur_p1 < r_count) begin
                                    n_ok  = 1'b1;
                                    n_cur = AW'(w_cur_p1);
                                end
                                n_state = ST_READ;
                            end
                        end
                        ACT_PRIOR: begin
                            if (w_ne) begin
                                if (r_cur != '0) begin
                                    n_ok  = 1'b1;
                                    n_cur = r_cur - AW'(1);
                                end
                                n_state = ST_READ;
                            end
                        end
                        ACT_CLEAR: begin
                            n_ok    = 1'b1;
                            n_count = '0;
                            n_cur   = '0;
                        end
                        default: begin
                            if (w_ne) begin
                                n_state = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                if (!r_rd_v) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = AW'(r_idx - CW'(1));
                    n_rd_v      = 1'b1;
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_idx);
                    o_mem_wdata = i_mem_rdata;
                    if ((r_idx - CW'(1)) == r_pos) begin
                        n_rd_v  = 1'b0;
                        n_state = ST_WRITE;
                    end else begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(r_idx - CW'(2));
                        n_idx       = r_idx - CW'(1);
                    end
                end
            end
            ST_SHIFT_DN: begin
                o_mem_re    = w_rd_issue;
                o_mem_raddr = AW'(r_idx);
                if (r_rd_v) begin
                    if ((r_idx - CW'(1)) == r_pos) begin
                        n_dout = i_mem_rdata;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = AW'(r_idx - CW'(2));
                        o_mem_wdata = i_mem_rdata;
                    end
                end
                n_rd_v = w_rd_issue;
                n_idx  = r_idx + CW'(1);
                if (!w_rd_issue) begin
                    n_state = ST_DONE;
                end
            end
            ST_WRITE: begin
                o_mem_we = 1'b1;
                n_state  = r_rd_after ? ST_READ : ST_DONE;
            end
            ST_READ: begin
                o_mem_re = 1'b1;
                n_state  = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                n_dout  = i_mem_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_flags.success  = r_ok;
    assign o_res_flags.is_empty = !w_ne;
    assign o_res_flags.is_full  = w_full;
    assign o_res_data           = r_dout;
    assign o_res_count          = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above depth");

    a_cursor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_cur == '0))
        else $error("cursor off zero on empty list");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CW'(r_cur) < r_count))
        else $error("cursor beyond tail");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && o_mem_re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("read and write on one entry in one cycle");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_res_ready) |=> (r_state == ST_DONE))
        else $error("result dropped before hand-off");

endmodule

`default_nettype wire

### rtl/core/bcl_obuf.sv
// output register stage between the sequencer and the result stream
`default_nettype none

module bcl_obuf #(
    parameter int W = 48
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic      [W-1:0] o_data
);
    import bcl_pkg::*;

    logic         r_valid;
    logic [W-1:0] r_data;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

### tb/sv/bcl_checker.sv
// beat monitor, list predictor and result comparison for the bounded cursor list
module bcl_checker #(
    parameter int MAX_ENTRIES = 64,
    parameter int OUT_W       = 48
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    // action [3:0], data_value [35:4], zero fill
    input  wire logic [39:0]               i_in_data,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    // success, data_out, entry_total, is_empty, is_full, zero fill
    input  wire logic [OUT_W-1:0]          i_out_data,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [bcl_pkg::CAP_W-1:0] i_cfg_wr_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_refused
);
    import bcl_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic              success;
        logic [DATA_W-1:0] data_out;
        logic [CNT_W-1:0]  entry_total;
        logic              is_empty;
        logic              is_full;
    } t_list_outcome;

    logic [DATA_W-1:0] shadow_store [MAX_ENTRIES];
    int unsigned       shadow_count;
    int unsigned       shadow_cursor;
    logic [CAP_W-1:0]  shadow_cap;
    t_list_outcome     due_outcomes [$];

    function automatic logic list_at_limit();
        int unsigned lim;
        lim = 32'(shadow_cap);
        if (lim < 1) lim = 1;
        if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
        return shadow_count >= lim;
    endfunction

    task automatic apply_list_action(input logic [ACT_W-1:0] code, input logic [DATA_W-1:0] val);
        t_list_outcome     res;
        logic              ok;
        logic              taken;
        logic [DATA_W-1:0] taken_val;
        int unsigned       slot;
        int unsigned       i;
        ok = 1'b0;
        taken = 1'b0;
        taken_val = '0;
        case (t_action'(code))
            ACT_INS_BEFORE, ACT_INS_AFTER: begin
                if (shadow_count == 0) begin
                    shadow_store[0] = val;
                    shadow_count = 1;
                    shadow_cursor = 0;
                    ok = 1'b1;
                end else if (!list_at_limit()) begin
                    slot = (code == ACT_INS_AFTER) ? shadow_cursor + 1 : shadow_cursor;
                    for (i = shadow_count; i > slot; i--)
                        shadow_store[i] = shadow_store[i - 1];
                    shadow_store[slot] = val;
                    shadow_count++;
                    shadow_cursor = slot;
                    ok = 1'b1;
                end
            end
            ACT_REP_BEFORE: begin
                if (shadow_count != 0 && shadow_cursor != 0) begin
                    shadow_store[shadow_cursor - 1] = val;
                    ok = 1'b1;
                end
            end
            ACT_REP_AT: begin
                if (shadow_count != 0) begin
                    shadow_store[shadow_cursor] = val;
                    ok = 1'b1;
                end
            end
            ACT_REP_AFTER: begin
                if (shadow_count != 0 && shadow_cursor + 1 < shadow_count) begin
                    shadow_store[shadow_cursor + 1] = val;
                    ok = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (shadow_count != 0) begin
                    taken_val = shadow_store[shadow_cursor];
                    for (i = shadow_cursor; i + 1 < shadow_count; i++)
                        shadow_store[i] = shadow_store[i + 1];
                    shadow_count--;
                    if (shadow_cursor >= shadow_count && shadow_cursor != 0)
                        shadow_cursor--;
                    taken = 1'b1;
                    ok = 1'b1;
                end
            end
            ACT_BEGIN: begin
                if (shadow_count != 0) begin
                    shadow_cursor = 0;
                    ok = 1'b1;
                end
            end
            ACT_END: begin
                if (shadow_count != 0) begin
                    shadow_cursor = shadow_count - 1;
                    ok = 1'b1;
                end
            end
            ACT_NEXT: begin
                if (shadow_count != 0 && shadow_cursor + 1 < shadow_count) begin
                    shadow_cursor++;
                    ok = 1'b1;
                end
            end
            ACT_PRIOR: begin
                if (shadow_count != 0 && shadow_cursor != 0) begin
                    shadow_cursor--;
                    ok = 1'b1;
                end
            end
            ACT_CLEAR: begin
                shadow_count = 0;
                shadow_cursor = 0;
                ok = 1'b1;
            end
            default: begin
            end
        endcase
        res.success = ok;
        if (taken)
            res.data_out = taken_val;
        else if (shadow_count != 0)
            res.data_out = shadow_store[shadow_cursor];
        else
            res.data_out = '0;
        res.entry_total = shadow_count[CNT_W-1:0];
        res.is_empty = (shadow_count == 0);
        res.is_full = list_at_limit();
        due_outcomes.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_outcome want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_cursor = 0;
            shadow_cap = CAP_RESET;
            due_outcomes.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_refused = 0;
        end else begin
            if (i_cfg_wr_en)
                shadow_cap = i_cfg_wr_data;
            if (i_in_valid && i_in_ready)
                apply_list_action(i_in_data[3:0], i_in_data[35:4]);
            if (i_out_valid && i_out_ready) begin
                if (due_outcomes.size() == 0) begin
                    $error("result beat with no action waiting for it");
                    o_fail_count++;
                end else begin
                    want = due_outcomes.pop_front();
                    check_field("success", DATA_W'(want.success), DATA_W'(i_out_data[0]));
                    check_field("data_out", want.data_out, i_out_data[DATA_W:1]);
                    check_field("entry_total", DATA_W'(want.entry_total),
                                DATA_W'(i_out_data[DATA_W+CNT_W:DATA_W+1]));
                    check_field("is_empty", DATA_W'(want.is_empty),
                                DATA_W'(i_out_data[DATA_W+CNT_W+1]));
                    check_field("is_full", DATA_W'(want.is_full),
                                DATA_W'(i_out_data[DATA_W+CNT_W+2]));
                    o_checked++;
                    if (!want.success)
                        o_refused++;
                end
            end
        end
        o_pending = due_outcomes.size();
    end

endmodule

### tb/sv/tb_bounded_cursor_list.sv
// stimulus, handshake pacing and verdict for the bounded cursor list
module tb_bounded_cursor_list;
    import bcl_pkg::*;

    localparam int MAX_ENTRIES = 64;
    localparam int OUT_W = ((35 + $clog2(MAX_ENTRIES + 1) + 7) / 8) * 8;
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 4'd11;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 4'd15;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 152;
    localparam int PHASE_CAP  [PHASES] = '{64, 3, 0, 1, 127, 8, 2, 100, 16, 65, 5, 64};
    localparam int PHASE_GROW [PHASES] = '{60, 10, 40, 50, 55, 45, 30, 60, 35, 50, 20, 40};

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // action [3:0], data_value [35:4], zero fill
    logic [39:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // success, data_out, entry_total, is_empty, is_full, zero fill
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               i_cfg_wr_en;
    logic [CAP_W-1:0]   i_cfg_wr_data;

    int fail_count;
    int pending;
    int checked;
    int refused;
    int sent_items;
    int cap_settings;
    int quiet_cycles;
    bit no_idle;

    bounded_cursor_list #(.MAX_ENTRIES(MAX_ENTRIES)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    bcl_checker #(.MAX_ENTRIES(MAX_ENTRIES), .OUT_W(OUT_W)) u_list_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_refused     (refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(7, 0);
    endfunction

    function automatic logic [DATA_W-1:0] draw_value();
        case ($urandom_range(5, 0))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return DATA_W'($urandom_range(15, 0));
            3: return -DATA_W'($urandom_range(15, 1));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] draw_action(input int grow_pct);
        int r;
        if ($urandom_range(99, 0) < grow_pct)
            return $urandom_range(1, 0) ? ACT_INS_AFTER : ACT_INS_BEFORE;
        r = $urandom_range(99, 0);
        if (r < 2)
            return ACT_CLEAR;
        if (r < 5)
            return ACT_W'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
        if (r < 25)
            return ACT_REMOVE;
        if (r < 45)
            return ACT_W'(ACT_REP_BEFORE + $urandom_range(2, 0));
        return ACT_W'(ACT_BEGIN + $urandom_range(3, 0));
    endfunction

    task automatic send_beat(input logic [ACT_W-1:0] code, input logic [DATA_W-1:0] val);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, val, code};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= cap;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cap_settings++;
    endtask

    // result side pacing
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("bounded_cursor_list regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        sent_items = 0;
        cap_settings = 0;
        no_idle = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty list refusals
        send_beat(ACT_REMOVE, 32'hFFFF_FFFF);
        send_beat(ACT_REP_AT, 32'h1234_5678);
        send_beat(ACT_REP_BEFORE, 32'h1);
        send_beat(ACT_NEXT, '0);
        send_beat(ACT_PRIOR, '0);
        // first entry, then edges of a two and three entry list
        send_beat(ACT_INS_BEFORE, 32'h7FFF_FFFF);
        send_beat(ACT_INS_AFTER, 32'h8000_0000);
        send_beat(ACT_REP_AFTER, 32'hDEAD_BEEF);
        send_beat(ACT_PRIOR, '0);
        send_beat(ACT_REP_BEFORE, 32'hDEAD_BEEF);
        send_beat(ACT_PRIOR, '0);
        send_beat(ACT_INS_BEFORE, 32'hFFFF_FFFF);
        send_beat(ACT_END, '0);
        send_beat(ACT_NEXT, '0);
        send_beat(ACT_REP_BEFORE, 32'h0);
        send_beat(ACT_BEGIN, '0);
        send_beat(ACT_REP_AFTER, 32'h5555_AAAA);
        send_beat(ACT_REP_AT, 32'hAAAA_5555);
        send_beat(ACT_SPARE_FIRST, 32'hFFFF_FFFF);
        send_beat(ACT_SPARE_LAST, 32'hFFFF_FFFF);
        send_beat(ACT_REMOVE, '0);
        send_beat(ACT_END, '0);
        send_beat(ACT_REMOVE, '0);
        send_beat(ACT_CLEAR, '0);
        send_beat(ACT_CLEAR, '0);

        for (int p = 0; p < PHASES; p++) begin
            set_capacity(CAP_W'(PHASE_CAP[p]));
            no_idle = (p % 4 == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(59, 0) == 0)
                    drain_results();
                send_beat(draw_action(PHASE_GROW[p]), draw_value());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("%0d list actions over %0d capacity settings, %0d results compared, %0d refused",
                 sent_items, cap_settings, checked, refused);
        if (fail_count == 0 && pending == 0)
            $display("bounded_cursor_list regression: pass");
        else
            $display("bounded_cursor_list regression: fail");
        $finish;
    end

endmodule
